@@ hw/rtl/tsbp_pkg.sv @@
package tsbp_pkg;

  // Input operation codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Stream constants.
  localparam logic [9:0]  PAD_WORD      = 10'h2aa;
  localparam logic [9:0]  BUNCH_LEN_MAX = 10'd1021;
  localparam logic [3:0]  TRL_ADDR_TAG  = 4'ha;        // 0xa0 over address bits 11:8
  localparam logic [5:0]  TRL_CNT_TAG   = 6'b101010;   // 0xa8 over count bits 9:8
  localparam logic [7:0]  TRL_TOP_TAG   = 8'haa;

  // Width of one packed result word and the number of results one beat can cause.
  localparam int unsigned WORD_W  = 40;
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DUP_TIME = 2'd1,
    ERR_RANGE    = 2'd2
  } err_code_t;

  // All results caused by one input beat, in output order.
  typedef struct packed {
    logic [1:0]                      num;
    err_code_t                       err;
    logic [MAX_RES-1:0]              trl;
    logic [MAX_RES-1:0][WORD_W-1:0]  word;
  } res_bundle_t;

endpackage

@@ hw/rtl/tsbp_pack.sv @@
module tsbp_pack
  import tsbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_sample,
  input  logic [9:0]  in_time_bin,
  input  logic [11:0] in_chan_addr,
  output logic        bndl_valid,
  input  logic        bndl_ready,
  output res_bundle_t bndl
);

  typedef enum logic [1:0] {
    ORD_UNKNOWN = 2'd0,
    ORD_ASC     = 2'd1,
    ORD_DESC    = 2'd2
  } order_t;

  // Input register.
  logic        valid_r;
  logic        func_r;
  logic [15:0] sample_r;
  logic [9:0]  time_r;
  logic [11:0] addr_r;

  // Packer state.
  logic            chan_open_r, chan_open_nxt;
  logic [11:0]     open_addr_r, open_addr_nxt;
  logic            prev_valid_r, prev_valid_nxt;
  logic [9:0]      prev_time_r, prev_time_nxt;
  order_t          order_r, order_nxt;
  logic [9:0]      bunch_len_r, bunch_len_nxt;
  logic [2:0][9:0] part_r, part_nxt;
  logic [1:0]      part_cnt_r, part_cnt_nxt;
  logic [9:0]      word_cnt_r, word_cnt_nxt;

  logic            fire;
  logic            is_flush, closing, pv, dup, asc, desc, cont, close_b, over, push_s, samp_in;
  err_code_t       err;
  logic [2:0][9:0] nw;
  logic [1:0]      nn;
  logic [2:0]      total;
  logic [5:0][9:0] slot;
  logic            has_a, has_p;
  logic [1:0]      rest_cnt;
  logic [2:0][9:0] rest;
  logic [3:0][9:0] pad_w;
  logic [9:0]      cnt_close;
  logic [39:0]     trl_w;
  logic [9:0]      bl_base;

  // A beat leaves the input register when its results fit, or when it has none.
  assign fire     = valid_r && (bndl_ready || (bndl.num == 2'd0));
  assign in_ready = !valid_r || fire;

  // Decode of the registered beat against the current state.
  always_comb begin
    is_flush = (func_r == FUNC_FLUSH);
    closing  = chan_open_r && (is_flush || (addr_r != open_addr_r));
    pv       = prev_valid_r && !closing && !is_flush;
    dup      = pv && (prev_time_r == time_r);
    asc      = (({1'b0, prev_time_r} + 11'd1) == {1'b0, time_r});
    desc     = ({1'b0, prev_time_r} == ({1'b0, time_r} + 11'd1));
    order_nxt = order_r;
    if (pv && !dup && (order_r == ORD_UNKNOWN)) begin
      if (asc) begin
        order_nxt = ORD_ASC;
      end else if (desc) begin
        order_nxt = ORD_DESC;
      end
    end
    cont    = ((order_nxt == ORD_ASC) && asc) || ((order_nxt == ORD_DESC) && desc);
    close_b = (bunch_len_r != 10'd0) && (closing || (pv && !dup && !cont));
    over    = (sample_r[15:10] != 6'd0);
    push_s  = !is_flush && !dup && !over;
    samp_in = push_s && !closing;
    if (is_flush) begin
      err = ERR_NONE;
    end else if (dup) begin
      err = ERR_DUP_TIME;
    end else if (over) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end
  end

  // New 10-bit words entering the stream: bunch close words, then the sample.
  always_comb begin
    if (close_b) begin
      nw[0] = prev_time_r;
      nw[1] = bunch_len_r + 10'd2;
      nw[2] = sample_r[9:0];
      nn    = samp_in ? 2'd3 : 2'd2;
    end else begin
      nw[0] = sample_r[9:0];
      nw[1] = 10'd0;
      nw[2] = 10'd0;
      nn    = samp_in ? 2'd1 : 2'd0;
    end
    total = {1'b0, part_cnt_r} + {1'b0, nn};
  end

  // Line up the held partial words with the new ones.
  always_comb begin
    logic [2:0] ni;
    ni = 3'd0;
    for (int i = 0; i < 6; i++) begin
      ni = 3'(i) - {1'b0, part_cnt_r};
      if (3'(i) < {1'b0, part_cnt_r}) begin
        slot[i] = part_r[i[1:0]];
      end else if (ni < 3'd3) begin
        slot[i] = nw[ni[1:0]];
      end else begin
        slot[i] = 10'd0;
      end
    end
  end

  // Full word, remainder and padded word.
  always_comb begin
    has_a    = (total >= 3'd4);
    rest_cnt = has_a ? 2'(total - 3'd4) : total[1:0];
    for (int j = 0; j < 2; j++) begin
      rest[j] = has_a ? slot[4 + j] : slot[j];
    end
    rest[2] = has_a ? 10'd0 : slot[2];
    for (int j = 0; j < 3; j++) begin
      pad_w[j] = (2'(j) < rest_cnt) ? rest[j] : PAD_WORD;
    end
    pad_w[3] = PAD_WORD;
    has_p    = closing && (rest_cnt != 2'd0);
    cnt_close = word_cnt_r + (close_b ? 10'd2 : 10'd0);
    trl_w    = {TRL_TOP_TAG, TRL_CNT_TAG, cnt_close[9:8], cnt_close[7:0],
                TRL_ADDR_TAG, open_addr_r[11:8], open_addr_r[7:0]};
  end

  // Gather the results of this beat in order.
  always_comb begin
    logic [1:0] idx;
    idx  = 2'd0;
    bndl = '0;
    bndl.err = err;
    if (has_a) begin
      bndl.word[idx] = slot[3:0];
      idx = idx + 2'd1;
    end
    if (has_p) begin
      bndl.word[idx] = pad_w;
      idx = idx + 2'd1;
    end
    if (closing) begin
      bndl.word[idx] = trl_w;
      bndl.trl[idx]  = 1'b1;
      idx = idx + 2'd1;
    end
    if ((idx == 2'd0) && (err != ERR_NONE)) begin
      idx = 2'd1;
    end
    bndl.num = idx;
  end

  assign bndl_valid = valid_r && (bndl.num != 2'd0);

  // Next state.
  always_comb begin
    if (closing) begin
      part_nxt     = {20'd0, sample_r[9:0]};
      part_cnt_nxt = push_s ? 2'd1 : 2'd0;
      word_cnt_nxt = push_s ? 10'd1 : 10'd0;
    end else begin
      part_nxt     = rest;
      part_cnt_nxt = rest_cnt;
      word_cnt_nxt = word_cnt_r + 10'(nn);
    end
    bl_base       = close_b ? 10'd0 : bunch_len_r;
    bunch_len_nxt = (push_s && (bl_base < BUNCH_LEN_MAX)) ? bl_base + 10'd1 : bl_base;
    chan_open_nxt  = !is_flush;
    open_addr_nxt  = is_flush ? open_addr_r : addr_r;
    prev_valid_nxt = !is_flush || (prev_valid_r && !closing);
    prev_time_nxt  = is_flush ? prev_time_r : time_r;
  end

  // Input register and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      chan_open_r  <= 1'b0;
      open_addr_r  <= 12'd0;
      prev_valid_r <= 1'b0;
      prev_time_r  <= 10'd0;
      order_r      <= ORD_UNKNOWN;
      bunch_len_r  <= 10'd0;
      part_r       <= '0;
      part_cnt_r   <= 2'd0;
      word_cnt_r   <= 10'd0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (fire) begin
        chan_open_r  <= chan_open_nxt;
        open_addr_r  <= open_addr_nxt;
        prev_valid_r <= prev_valid_nxt;
        prev_time_r  <= prev_time_nxt;
        order_r      <= order_nxt;
        bunch_len_r  <= bunch_len_nxt;
        part_r       <= part_nxt;
        part_cnt_r   <= part_cnt_nxt;
        word_cnt_r   <= word_cnt_nxt;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r   <= in_func;
      sample_r <= in_sample;
      time_r   <= in_time_bin;
      addr_r   <= in_chan_addr;
    end
  end

endmodule

@@ hw/rtl/tsbp_outq.sv @@
module tsbp_outq
  import tsbp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  res_bundle_t push_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_packed_word,
  output logic        out_is_trailer,
  output logic        out_is_last,
  output logic [1:0]  out_error_code
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_bundle_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    sub_r;
  res_bundle_t   head;
  logic          push, pop, beat;

  assign head       = mem[rd_ptr_r];
  assign push_ready = (cnt_r != CW'(DEPTH));
  assign push       = push_valid && push_ready;
  assign out_valid  = (cnt_r != '0);
  assign out_is_last     = (sub_r == (head.num - 2'd1));
  assign out_packed_word = head.word[sub_r];
  assign out_is_trailer  = head.trl[sub_r];
  assign out_error_code  = out_is_last ? head.err : ERR_NONE;
  assign beat = out_valid && out_ready;
  assign pop  = beat && out_is_last;

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers, fill count and position inside the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (beat) begin
        sub_r <= out_is_last ? 2'd0 : sub_r + 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/tenbit_sample_bunch_packer.sv @@
// Packs (sample, time bin, channel address) beats into 40-bit words holding
// four 10-bit words each, first word in bits 9:0.
// Input channel: in_valid/in_ready with in_func (add sample or flush),
// in_sample, in_time_bin and in_chan_addr. Output channel: out_valid/out_ready
// with out_packed_word, out_is_trailer, out_is_last and out_error_code.
// One input beat causes zero to three result beats; out_is_last marks the
// last of them, and only that beat carries the error code.
// The first result of a beat is offered once the beat has passed the input
// register and been written into the result queue.
// Throughput: one input beat per cycle while the result queue has room. All
// packing for a beat is combinational between the input register and the
// result queue, so the rate is set by the output side: at most one result
// beat leaves per cycle, and the queue of DEPTH bundles absorbs channel-close
// bursts of up to three. When the receiver stalls, the queue fills and
// in_ready drops once it is full; beats that cause no result still pass.
// Reset (synchronous, active low) empties the queue and clears all packing
// state: no channel open, no partial words, bunch direction unknown.
module tenbit_sample_bunch_packer
  import tsbp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_sample,
  input  logic [9:0]  in_time_bin,
  input  logic [11:0] in_chan_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_packed_word,
  output logic        out_is_trailer,
  output logic        out_is_last,
  output logic [1:0]  out_error_code
);

  logic        bndl_valid;
  logic        bndl_ready;
  res_bundle_t bndl;

  // Packing logic and state.
  tsbp_pack u_pack (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_sample    (in_sample),
    .in_time_bin  (in_time_bin),
    .in_chan_addr (in_chan_addr),
    .bndl_valid   (bndl_valid),
    .bndl_ready   (bndl_ready),
    .bndl         (bndl)
  );

  // Result queue, one bundle per input beat that causes results.
  tsbp_outq #(
    .DEPTH (DEPTH)
  ) u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_valid      (bndl_valid),
    .push_ready      (bndl_ready),
    .push_data       (bndl),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_is_trailer  (out_is_trailer),
    .out_is_last     (out_is_last),
    .out_error_code  (out_error_code)
  );

endmodule

@@ hw/rtl/tsbp_chk.sv @@
module tsbp_chk
  import tsbp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_packed_word,
  input logic        out_is_trailer,
  input logic        out_is_last,
  input logic [1:0]  out_error_code
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packed_word)
      && $stable(out_is_trailer) && $stable(out_is_last) && $stable(out_error_code))
    else $error("result beat changed while stalled");

  // Only the last result of an input carries an error code.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_error_code == ERR_NONE)
    else $error("error code on a result that is not the last");

  // A trailer closes the results of its input.
  a_trl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_trailer |-> out_is_last)
    else $error("trailer is not the last result");

  // Trailer words carry their fixed tags.
  a_trl_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_trailer |-> (out_packed_word[39:32] == TRL_TOP_TAG)
      && (out_packed_word[31:26] == TRL_CNT_TAG) && (out_packed_word[15:12] == TRL_ADDR_TAG))
    else $error("trailer tags wrong");

endmodule

bind tenbit_sample_bunch_packer tsbp_chk u_chk (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import tsbp_pkg::*;
();

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [15:0] SAMPLE_MAX = 16'd1023;

  // Bunch direction as tracked by the predictor.
  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_UP      = 2'd1,
    DIR_DOWN    = 2'd2
  } bunch_dir_t;

  // Receiver behaviors, each held for a random span before the next is picked.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_BLOCKS
  } rx_mode_t;

  // One expected result beat.
  typedef struct packed {
    logic [39:0] word;
    logic        trl;
    logic        last;
    err_code_t   err;
  } packed_res_t;

  // Predicts the packed stream and checks result beats against it in order.
  class bunch_scoreboard;
    bit          chan_open;
    bit [11:0]   open_addr;
    bit          prev_valid;
    bit [9:0]    prev_time;
    bunch_dir_t  order;
    bit [9:0]    bunch_len;
    bit [29:0]   part_words;
    bit [1:0]    part_cnt;
    bit [15:0]   word_cnt;
    bit [39:0]   new_words[$];
    bit          new_trl[$];
    packed_res_t expected_q[$];
    int          n_mismatch;
    int          n_results;
    int          n_trailers;
    int          n_dup;
    int          n_range;

    // Queue one 40-bit word caused by the current beat.
    function void put_word(bit [39:0] w, bit trl);
      new_words = {new_words, w};
      new_trl = {new_trl, trl};
    endfunction

    // Append one 10-bit word; every fourth one completes a 40-bit word.
    function void add_word(bit [9:0] v);
      if (part_cnt == 2'd3) begin
        put_word({v, part_words}, 1'b0);
        part_words = '0;
        part_cnt = '0;
      end else begin
        part_words[10*part_cnt +: 10] = v;
        part_cnt++;
      end
    endfunction

    function void add_counted(bit [9:0] v);
      add_word(v);
      word_cnt++;
    endfunction

    // A bunch ends with its last time bin and its length plus two.
    function void end_bunch();
      if (bunch_len != 0) begin
        add_counted(prev_time);
        add_counted(bunch_len + 10'd2);
        bunch_len = '0;
      end
    endfunction

    // Close the open channel: pad to a full word, then the trailer.
    function void end_channel();
      bit [9:0] cnt;
      end_bunch();
      cnt = word_cnt[9:0];
      while (part_cnt != 0) add_word(PAD_WORD);
      put_word({TRL_TOP_TAG, TRL_CNT_TAG, cnt[9:8], cnt[7:0],
                TRL_ADDR_TAG, open_addr}, 1'b1);
      word_cnt = '0;
      prev_valid = 1'b0;
      chan_open = 1'b0;
    endfunction

    // Work out every result one accepted input beat causes.
    function void note_beat(logic func, logic [15:0] smp, logic [9:0] tb,
                            logic [11:0] addr);
      err_code_t   err;
      bit          up_next;
      bit          down_next;
      int          n;
      packed_res_t r;
      err = ERR_NONE;
      new_words.delete();
      new_trl.delete();
      if (func == FUNC_FLUSH) begin
        if (chan_open) end_channel();
      end else begin
        if (chan_open && addr != open_addr) end_channel();
        chan_open = 1'b1;
        open_addr = addr;
        if (prev_valid && prev_time == tb) begin
          err = ERR_DUP_TIME;
        end else begin
          if (prev_valid) begin
            up_next = (int'(prev_time) + 1 == int'(tb));
            down_next = (int'(prev_time) == int'(tb) + 1);
            if (order == DIR_UNKNOWN) begin
              if (up_next) order = DIR_UP;
              else if (down_next) order = DIR_DOWN;
            end
            if (!((order == DIR_UP && up_next) || (order == DIR_DOWN && down_next)))
              end_bunch();
          end
          if (smp > SAMPLE_MAX) begin
            err = ERR_RANGE;
          end else begin
            add_counted(smp[9:0]);
            if (bunch_len < BUNCH_LEN_MAX) bunch_len++;
          end
          prev_valid = 1'b1;
          prev_time = tb;
        end
      end
      if (err == ERR_DUP_TIME) n_dup++;
      if (err == ERR_RANGE) n_range++;
      // A flagged beat with no word still returns one status beat.
      if (err != ERR_NONE && new_words.size() == 0) begin
        put_word('0, 1'b0);
      end
      n = (new_words.size() > MAX_RES) ? MAX_RES : new_words.size();
      for (int k = 0; k < n; k++) begin
        r.word = new_words[k];
        r.trl = new_trl[k];
        r.last = (k == n - 1);
        r.err = r.last ? err : ERR_NONE;
        expected_q = {expected_q, r};
      end
    endfunction

    task report(string what);
      n_mismatch++;
      if (n_mismatch <= 40) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task check_result(logic [39:0] w, logic trl, logic last, logic [1:0] err);
      packed_res_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", w));
        return;
      end
      e = expected_q.pop_front();
      n_results++;
      if (e.trl) n_trailers++;
      if (w !== e.word)
        report($sformatf("packed_word %h, expected %h", w, e.word));
      if (trl !== e.trl)
        report($sformatf("is_trailer %b, expected %b (word %h)", trl, e.trl, e.word));
      if (last !== e.last)
        report($sformatf("is_last %b, expected %b (word %h)", last, e.last, e.word));
      if (err !== e.err)
        report($sformatf("error_code %0d, expected %0d (word %h)", err, e.err, e.word));
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task close_out();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected result beats never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [15:0] in_sample;
  logic [9:0]  in_time_bin;
  logic [11:0] in_chan_addr;
  logic        out_valid;
  logic        out_ready;
  logic [39:0] out_packed_word;
  logic        out_is_trailer;
  logic        out_is_last;
  logic [1:0]  out_error_code;

  bunch_scoreboard sb;
  int          cycle_cnt;
  int          n_beats;
  int          n_flush;
  int          burst_left;
  int          step;
  logic [11:0] cur_addr;
  logic [9:0]  last_tb;
  rx_mode_t    rx_mode;
  int          rx_span;
  int          stall_left;

  tenbit_sample_bunch_packer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_sample      (in_sample),
    .in_time_bin    (in_time_bin),
    .in_chan_addr   (in_chan_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_word(out_packed_word),
    .out_is_trailer (out_is_trailer),
    .out_is_last    (out_is_last),
    .out_error_code (out_error_code)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d result beats pending", sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor: every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_packed_word, out_is_trailer, out_is_last, out_error_code);
  end

  // Receiver: switches between always ready, random stalls and stall blocks.
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 80);
    end
    rx_span--;
    case (rx_mode)
      RX_OPEN: out_ready = 1'b1;
      RX_MOSTLY: out_ready = ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          out_ready = 1'b0;
          stall_left--;
        end else begin
          out_ready = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(4, 16);
        end
      end
    endcase
  end

  // Drive one input beat, with a random gap at the start of each burst.
  task send_beat(logic func, logic [15:0] smp, logic [9:0] tb, logic [11:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_func = func;
    in_sample = smp;
    in_time_bin = tb;
    in_chan_addr = addr;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(func, smp, tb, addr);
    n_beats++;
    if (func == FUNC_FLUSH) n_flush++;
    else last_tb = tb;
  endtask

  task add_beat(logic [15:0] smp, logic [9:0] tb, logic [11:0] addr);
    send_beat(FUNC_ADD, smp, tb, addr);
  endtask

  // The payload of a flush is don't-care, so it carries random bits.
  task flush_beat();
    send_beat(FUNC_FLUSH, 16'($urandom), 10'($urandom), 12'($urandom));
  endtask

  // Hold the sender until every expected result beat has left.
  task drain_pause();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // A bunch of consecutive bins in the fixed direction, with the odd
  // out-of-range sample and duplicated bin mixed in.
  task run_bunch(logic [11:0] addr, int len);
    int          first;
    logic [9:0]  tb;
    logic [15:0] v;
    first = (step > 0) ? $urandom_range(0, 1024 - len) : $urandom_range(len - 1, 1023);
    for (int k = 0; k < len; k++) begin
      tb = 10'(first + k * step);
      v = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(1024, 65535))
                                      : 16'($urandom_range(0, 1023));
      add_beat(v, tb, addr);
      if ($urandom_range(0, 14) == 0) add_beat(16'($urandom_range(0, 1023)), tb, addr);
    end
  endtask

  initial begin
    int s_bin;
    int e_bin;
    int goal;
    int pick;

    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ADD;
    in_sample = '0;
    in_time_bin = '0;
    in_chan_addr = '0;
    cycle_cnt = 0;
    rx_span = 0;
    stall_left = 0;
    burst_left = 0;
    cur_addr = '0;
    last_tb = '0;
    step = ($urandom_range(0, 1) == 0) ? 1 : -1;
    s_bin = (step > 0) ? 0 : 1023;
    e_bin = 1023 - s_bin;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: corner values and each special case in turn.
    flush_beat();                                           // nothing open yet
    add_beat(16'hffff, 10'(s_bin), 12'h000);                // over range, opens channel
    add_beat(16'h0000, 10'(s_bin), 12'h000);                // duplicate bin
    add_beat(16'h03ff, 10'(s_bin + step), 12'h000);         // fixes the direction
    add_beat(16'h0400, 10'(s_bin + 2 * step), 12'h000);     // over range inside a bunch
    add_beat(16'h0155, 10'(s_bin + 3 * step), 12'h000);
    add_beat(16'h02aa, 10'(s_bin + 5 * step), 12'h000);     // skipped bin breaks
    add_beat(16'h0001, 10'(s_bin + 4 * step), 12'h000);     // reverse step breaks
    add_beat(16'h0200, 10'(s_bin + 5 * step), 12'h000);
    add_beat(16'h0123, 10'(s_bin), 12'hfff);                // channel change
    add_beat(16'h0321, 10'(e_bin - step), 12'hfff);
    add_beat(16'h03ff, 10'(e_bin), 12'hfff);
    flush_beat();
    flush_beat();                                           // already closed
    add_beat(16'h8000, 10'd512, 12'h5a5);                   // flagged sample opens channel
    flush_beat();                                           // trailer with no words
    add_beat(16'h03ff, 10'd512, 12'ha5a);                   // same bin, fresh channel
    add_beat(16'h0000, 10'(512 + step), 12'ha5a);
    add_beat(16'h0077, 10'(512 + 2 * step), 12'h000);
    flush_beat();
    drain_pause();

    // Random part: mostly well-formed bunches, plus jumps, noise and flushes.
    goal = 200;
    while (n_beats < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 11) == 0)
        cur_addr = ($urandom_range(0, 3) == 0) ? {12{1'($urandom_range(0, 1))}}
                                              : 12'($urandom);
      if (pick < 60) begin
        run_bunch(cur_addr, $urandom_range(1, 10));
        if ($urandom_range(0, 4) == 0) flush_beat();
      end else if (pick < 75) begin
        repeat (3)
          add_beat(16'($urandom_range(0, 1023)),
                   10'(int'(last_tb) + $urandom_range(0, 4) - 2), cur_addr);
      end else if (pick < 90) begin
        send_beat(($urandom_range(0, 3) == 0) ? FUNC_FLUSH : FUNC_ADD,
                  16'($urandom), 10'($urandom), 12'($urandom));
      end else begin
        flush_beat();
      end
    end
    flush_beat();

    // Let the last results out.
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.close_out();

    $display("Sent %0d beats (%0d flushes, %0d duplicate bins, %0d samples over range).",
             n_beats, n_flush, sb.n_dup, sb.n_range);
    $display("Checked %0d result beats, %0d of them trailers; bunch direction %s.",
             sb.n_results, sb.n_trailers, (step > 0) ? "ascending" : "descending");
    if (sb.n_mismatch == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
